@@ hdl/i2a_pkg.sv @@
// Shared types, codes and helpers for the integer to ASCII digit converter.
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned BIN_BITS   = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned NIBBLES    = VALUE_BITS / 4;
  localparam int unsigned REM_BITS   = $clog2(NIBBLES + 1);
  localparam int unsigned STEP_BITS  = $clog2(BIN_BITS + 1);

  typedef enum logic [1:0] {
    OP_HEX  = 2'd0,
    OP_UDEC = 2'd1,
    OP_SDEC = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LOAD
  } ctrl_state_t;

  // request from the control FSM to the digit emitter
  typedef struct packed {
    logic                      load;
    logic                      neg;
    logic [VALUE_BITS-1:0]     digits;
  } emit_load_t;

  function automatic logic [6:0] nibble_char(input logic [3:0] n);
    logic [6:0] c;
    if (n < 4'd10) c = 7'h30 + {3'b000, n};
    else           c = 7'h57 + {3'b000, n};
    return c;
  endfunction

endpackage

@@ hdl/i2a_dabble.sv @@
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
`timescale 1ns / 1ps

module i2a_dabble (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [i2a_pkg::BIN_BITS-1:0]            mag,
  output logic [4*i2a_pkg::BCD_DIGITS-1:0]        bcd,
  output logic                                    done
);

  logic [i2a_pkg::BIN_BITS-1:0]      sh;
  logic [i2a_pkg::STEP_BITS-1:0]     steps;
  logic                              busy;
  logic [4*i2a_pkg::BCD_DIGITS-1:0]  bcd_adj;

  // digits >= 5 get +3 before the shift so they carry correctly
  always_comb begin
    for (int d = 0; d < int'(i2a_pkg::BCD_DIGITS); d++) begin
      if (bcd[4*d +: 4] >= 4'd5) bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      else                       bcd_adj[4*d +: 4] = bcd[4*d +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        sh    <= mag;
        bcd   <= '0;
        steps <= i2a_pkg::STEP_BITS'(i2a_pkg::BIN_BITS);
      end else if (busy) begin
        bcd   <= {bcd_adj[4*i2a_pkg::BCD_DIGITS-2:0], sh[i2a_pkg::BIN_BITS-1]};
        sh    <= {sh[i2a_pkg::BIN_BITS-2:0], 1'b0};
        steps <= steps - 1'b1;
        if (steps == i2a_pkg::STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/i2a_emit.sv @@
// Digit shift-out: drops leading zero nibbles, then emits one ASCII digit per output handshake.
`timescale 1ns / 1ps

module i2a_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  i2a_pkg::emit_load_t  ld,
  output logic                 busy,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [6:0] digit_char, [7] zero
  output logic                 m_tlast,   // is_last
  output logic                 m_tuser    // is_negative
);

  logic [i2a_pkg::VALUE_BITS-1:0] digs;
  logic [i2a_pkg::REM_BITS-1:0]   rem;
  logic                           neg;
  logic                           started;
  logic [3:0]                     top;
  logic                           skip;

  assign top  = digs[i2a_pkg::VALUE_BITS-1 -: 4];
  // leading zero, but the final nibble is always shown
  assign skip = !started && top == 4'd0 && rem > i2a_pkg::REM_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      started  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (busy && !skip && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready)                            m_tvalid <= 1'b0;
      if (ld.load && !busy) begin
        digs    <= ld.digits;
        neg     <= ld.neg;
        rem     <= i2a_pkg::REM_BITS'(i2a_pkg::NIBBLES);
        busy    <= 1'b1;
        started <= 1'b0;
      end else if (busy) begin
        if (skip) begin
          digs <= {digs[i2a_pkg::VALUE_BITS-5:0], 4'd0};
          rem  <= rem - 1'b1;
        end else if (!m_tvalid || m_tready) begin
          m_tdata  <= {1'b0, i2a_pkg::nibble_char(top)};
          m_tlast  <= (rem == i2a_pkg::REM_BITS'(1));
          m_tuser  <= neg;
          digs     <= {digs[i2a_pkg::VALUE_BITS-5:0], 4'd0};
          rem      <= rem - 1'b1;
          started  <= 1'b1;
          if (rem == i2a_pkg::REM_BITS'(1)) busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ hdl/integer_to_ascii_digits.sv @@
// Top level: integer to ASCII hex / decimal digit stream converter.
//
//   channel  dir  tdata                 tuser             tlast
//   s_*      in   [63:0] value          [1:0] opcode      -
//   m_*      out  [6:0] digit_char      [0] is_negative   is_last
//
// One request at a time. Hex: the value goes through the load state into the emitter,
// which skips leading zero nibbles and then emits one digit per nibble. Decimal: the
// value runs through the bit-serial BCD converter, then the same load and 16-nibble shift-out.
// The next request is taken once the previous one is loaded into the emitter.
// Opcode 3 is taken and dropped. Reset is synchronous; no clearing pass.
// Output stalls hold the emitter; m_tdata/m_tlast/m_tuser hold while stalled.
`timescale 1ns / 1ps

module integer_to_ascii_digits (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] digit_char, [7] zero
  output logic        m_tlast,   // is_last
  output logic        m_tuser    // is_negative
);

  i2a_pkg::ctrl_state_t                  state, state_next;
  logic [i2a_pkg::VALUE_BITS-1:0]        digits;
  logic                                  neg;
  logic                                  dec_mode;
  logic                                  accept;
  logic                                  conv_start;
  logic [i2a_pkg::BIN_BITS-1:0]          mag;
  logic [4*i2a_pkg::BCD_DIGITS-1:0]      bcd;
  logic                                  conv_done;
  logic                                  emit_busy;
  i2a_pkg::emit_load_t                   ld;
  i2a_pkg::opcode_t                      op;

  assign op       = i2a_pkg::opcode_t'(s_tuser);
  assign s_tready = (state == i2a_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (op == i2a_pkg::OP_SDEC && s_tdata[31]) mag = ~s_tdata[31:0] + 32'd1;
    else                                       mag = s_tdata[31:0];
  end

  always_comb begin
    state_next = state;
    conv_start = 1'b0;
    ld.load    = 1'b0;
    ld.neg     = neg;
    ld.digits  = dec_mode
               ? {{(i2a_pkg::VALUE_BITS - 4*i2a_pkg::BCD_DIGITS){1'b0}}, bcd}
               : digits;
    unique case (state)
      i2a_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            i2a_pkg::OP_HEX:  state_next = i2a_pkg::ST_LOAD;
            i2a_pkg::OP_UDEC,
            i2a_pkg::OP_SDEC: begin
              conv_start = 1'b1;
              state_next = i2a_pkg::ST_CONV;
            end
            default:          state_next = i2a_pkg::ST_IDLE;
          endcase
        end
      end
      i2a_pkg::ST_CONV: begin
        if (conv_done) state_next = i2a_pkg::ST_LOAD;
      end
      i2a_pkg::ST_LOAD: begin
        if (!emit_busy) begin
          ld.load    = 1'b1;
          state_next = i2a_pkg::ST_IDLE;
        end
      end
      default: state_next = i2a_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= i2a_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      digits   <= s_tdata;
      dec_mode <= (op != i2a_pkg::OP_HEX);
      neg      <= (op == i2a_pkg::OP_SDEC) && s_tdata[31];
    end
  end

  i2a_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .mag   (mag),
    .bcd   (bcd),
    .done  (conv_done)
  );

  i2a_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .busy     (emit_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

@@ dv/integer_to_ascii_digits_tb.sv @@
// Self-checking testbench for the integer to ASCII digit stream converter.
`timescale 1ns / 1ps

module integer_to_ascii_digits_tb;

  localparam int unsigned RANDOM_REQUESTS = 387;
  localparam int unsigned DRAIN_CYCLES    = 120;
  localparam int unsigned HOLD_OFF_CYCLES = 500;

  typedef struct {
    logic [6:0] digit_char;
    logic       is_last;
    logic       is_negative;
  } digit_t;

  class digit_scoreboard;
    digit_t pending_digits[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    // convert one request into the digit string the block should emit
    function void note_request(i2a_pkg::opcode_t op, logic [63:0] value);
      logic [63:0] mag;
      logic [63:0] radix;
      logic [31:0] low;
      logic        neg;
      logic [3:0]  rev [16];
      int          n;
      digit_t      d;
      neg = 1'b0;
      n = 0;
      low = value[31:0];
      case (op)
        i2a_pkg::OP_HEX: begin
          mag = value;
          radix = 64'd16;
        end
        i2a_pkg::OP_UDEC: begin
          mag = {32'd0, low};
          radix = 64'd10;
        end
        i2a_pkg::OP_SDEC: begin
          neg = low[31];
          if (neg) low = ~low + 32'd1;
          mag = {32'd0, low};
          radix = 64'd10;
        end
        default: return;
      endcase
      do begin
        rev[n] = 4'(mag % radix);
        mag = mag / radix;
        n++;
      end while (mag != 64'd0 && n < 16);
      for (int k = 0; k < n; k++) begin
        if (rev[n-1-k] < 4'd10) d.digit_char = 7'h30 + 7'(rev[n-1-k]);
        else                     d.digit_char = 7'h61 + 7'(rev[n-1-k] - 4'd10);
        d.is_last = (k == n - 1);
        d.is_negative = neg;
        pending_digits.push_back(d);
      end
    endfunction

    function void check_digit(logic [6:0] digit_char, logic is_last, logic is_negative);
      digit_t want;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit char=%h last=%b neg=%b",
                 $time, digit_char, is_last, is_negative);
        errors++;
        return;
      end
      want = pending_digits.pop_front();
      if (digit_char !== want.digit_char) begin
        $display("%0t: digit_char mismatch expected %h actual %h",
                 $time, want.digit_char, digit_char);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $display("%0t: is_last mismatch expected %b actual %b",
                 $time, want.is_last, is_last);
        errors++;
      end
      if (is_negative !== want.is_negative) begin
        $display("%0t: is_negative mismatch expected %b actual %b",
                 $time, want.is_negative, is_negative);
        errors++;
      end
    endfunction

    function int pending();
      return pending_digits.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = 64'd0;            // [63:0] value
  logic [1:0]  s_tuser = i2a_pkg::OP_HEX;  // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;                    // [6:0] digit_char, [7] zero
  logic        m_tlast;                    // is_last
  logic        m_tuser;                    // is_negative

  digit_scoreboard sb = new();
  int requests_sent = 0;
  int burst_left = 0;
  int digits_seen = 0;

  integer_to_ascii_digits DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("integer_to_ascii_digits_tb NOT OK");
    $finish;
  end

  // offer one request and hold it until taken; valid stays up for a back-to-back follow-on
  task automatic offer_request(input i2a_pkg::opcode_t op, input logic [63:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(op, value);
    requests_sent++;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [63:0] p;
    int          kind;
    int          w;
    kind = $urandom_range(0, 9);
    v = {$urandom, $urandom};
    case (kind)
      6: v = 64'd1 << (4 * $urandom_range(0, 15));
      7, 8: begin
        p = 64'd1;
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        v = (kind == 8) ? p - 64'd1 : p;
      end
      9: ;
      default: begin
        w = $urandom_range(1, 64);
        if (w < 64) v = v & ((64'd1 << w) - 64'd1);
      end
    endcase
    return v;
  endfunction

  // receiver: checks digits and drives ready on a changing pattern
  initial begin
    int mode;
    int phase;
    int hold_left;
    bit hold_done;
    mode = 0;
    phase = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_digit(m_tdata[6:0], m_tlast, m_tuser);
        digits_seen++;
      end
      if (!hold_done && digits_seen >= 400) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1;
      end
      phase++;
      if (phase % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          2: m_tready <= (phase % 4 == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    i2a_pkg::opcode_t op;
    logic [63:0]      v;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    offer_request(i2a_pkg::OP_HEX,  64'd0);
    offer_request(i2a_pkg::OP_UDEC, 64'd0);
    offer_request(i2a_pkg::OP_SDEC, 64'd0);
    offer_request(i2a_pkg::OP_HEX,  64'hFFFF_FFFF_FFFF_FFFF);
    offer_request(i2a_pkg::OP_HEX,  64'h8000_0000_0000_0000);
    offer_request(i2a_pkg::OP_HEX,  64'h1000_0000_0000_0000);
    offer_request(i2a_pkg::OP_HEX,  64'd16);
    offer_request(i2a_pkg::OP_HEX,  64'd15);
    offer_request(i2a_pkg::OP_HEX,  64'h0123_4567_89AB_CDEF);
    offer_request(i2a_pkg::OP_UDEC, 64'd10);
    offer_request(i2a_pkg::OP_UDEC, 64'd9);
    offer_request(i2a_pkg::OP_UDEC, 64'd1_000_000_000);
    offer_request(i2a_pkg::OP_UDEC, 64'h0000_0000_FFFF_FFFF);
    offer_request(i2a_pkg::OP_UDEC, 64'hDEAD_BEEF_0000_0010);  // upper bits ignored
    offer_request(i2a_pkg::OP_SDEC, 64'h0000_0000_8000_0000);  // most negative
    offer_request(i2a_pkg::OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_request(i2a_pkg::OP_SDEC, 64'h0000_0000_7FFF_FFFF);
    offer_request(i2a_pkg::OP_SDEC, 64'hFFFF_FFFF_FFFF_FFF6);
    offer_request(i2a_pkg::OP_SDEC, 64'h1234_5678_0000_000A);
    offer_request(i2a_pkg::OP_NONE, 64'h0000_0000_0000_0042);  // dropped, no digits
    offer_request(i2a_pkg::OP_HEX,  64'd1);
    offer_request(i2a_pkg::OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_request(i2a_pkg::OP_UDEC, 64'd1);

    requests_sent = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 19) == 0) op = i2a_pkg::OP_NONE;
      else op = i2a_pkg::opcode_t'($urandom_range(0, 2));
      v = random_value();
      if (op != i2a_pkg::OP_HEX && $urandom_range(0, 3) == 0) v[63:32] = $urandom;
      if (op == i2a_pkg::OP_SDEC && $urandom_range(0, 1) == 1) v[31:0] = ~v[31:0] + 32'd1;
      offer_request(op, v);
    end
    s_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("integer_to_ascii_digits_tb OK");
    end else begin
      $display("integer_to_ascii_digits_tb NOT OK");
    end
    $finish;
  end

endmodule
